### sv/assert_macros.svh
// Assertion macros for the quintic joint trajectory block.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QJT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qjt assertion failed");
`define QJT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qjt assertion failed");
`else
`define QJT_ASSERT(lbl, prop)
`define QJT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/qjt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and constants of the quintic joint trajectory block.
// No dependencies.
package qjt_pkg;
  localparam int POS_W     = 24;
  localparam int TIME_W    = 32;
  localparam int LIM_W     = 16;
  localparam int JIDX_W    = 3;
  localparam int CFG_W     = 3;
  localparam int MAX_JOINTS_DEF = 6;
  localparam logic [CFG_W-1:0] JOINTS_RST = 3'd6;
  localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
endpackage

### sv/qjt_if.sv
`timescale 1ns / 1ps
// Item channels of the quintic joint trajectory block: load/tick input and
// position command output. Depends on qjt_pkg.
interface qjt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [qjt_pkg::JIDX_W-1:0]        joint_index;
  logic                              first_of_motion;
  logic signed [qjt_pkg::POS_W-1:0]  start_position;
  logic signed [qjt_pkg::POS_W-1:0]  final_position;
  logic [qjt_pkg::LIM_W-1:0]         velocity_limit;
  logic [qjt_pkg::LIM_W-1:0]         accel_limit;
  logic [qjt_pkg::TIME_W-1:0]        time_now;
  modport source (output valid, op, joint_index, first_of_motion, start_position,
                  final_position, velocity_limit, accel_limit, time_now,
                  input ready);
  modport sink (input valid, op, joint_index, first_of_motion, start_position,
                final_position, velocity_limit, accel_limit, time_now,
                output ready);
endinterface

interface qjt_out_if;
  logic                              valid;
  logic                              ready;
  logic [qjt_pkg::JIDX_W-1:0]        joint_out;
  logic signed [qjt_pkg::POS_W-1:0]  position_command;
  logic                              last_joint;
  modport source (output valid, joint_out, position_command, last_joint, input ready);
  modport sink (input valid, joint_out, position_command, last_joint, output ready);
endinterface

### sv/quintic_joint_trajectory.sv
`timescale 1ns / 1ps
// Quintic point-to-point trajectory generator, top level.
// Depends on qjt_pkg, qjt_if and assert_macros.svh.
//
// Usage: in_if carries load items (op 0) and tick items (op 1); out_if carries
// one position command per joint in use for each tick, the last flagged by
// last_joint. cfg_we/cfg_wdata set the joint count; the user must write it
// only while the block is idle, which the block does not enforce. One shared
// 34x34 multiplier and one radix-2 divider do all but constant scalings. A
// load runs two 64-step divisions for the velocity and acceleration times,
// then 27 steps of the square root search; a load to a joint outside the
// count is dropped. A tick runs a 64-step phase division (none once the
// motion is over or the duration is zero), the polynomial steps S_TSQ, S_TCU,
// S_TP and S_TPR, then a multiply and an output step per joint. The input is
// not ready while an item is at work. The result register lets the next item
// in while the last command waits; a stalled receiver holds the per-joint
// loop until the result register frees. Reset clears duration, start time and
// the joint count (to 6); the angle stores hold garbage until loaded.
module quintic_joint_trajectory #(
  parameter int MAX_JOINTS = qjt_pkg::MAX_JOINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [qjt_pkg::CFG_W-1:0] cfg_wdata,
  qjt_in_if.sink                    in_if,
  qjt_out_if.source                 out_if
);
  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_LMUL   = 15'h0002,
    S_LDIV1  = 15'h0004,
    S_LDIV2  = 15'h0008,
    S_SQMUL  = 15'h0010,
    S_SQCMP  = 15'h0020,
    S_SQFIXM = 15'h0040,
    S_SQFIXC = 15'h0080,
    S_TDIV   = 15'h0100,
    S_TSQ    = 15'h0200,
    S_TCU    = 15'h0400,
    S_TP     = 15'h0800,
    S_TPR    = 15'h1000,
    S_JMUL   = 15'h2000,
    S_JOUT   = 15'h4000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    cfg_r;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [63:0]   quo_r, quo_nxt;
  logic [31:0]   dvs_r, dvs_nxt;
  logic [67:0]   prod_r;
  logic [31:0]   dur_r, dur_nxt;
  logic [31:0]   tstart_r, tstart_nxt;
  logic [24:0]   d_r, d_nxt;
  logic [15:0]   v_r, v_nxt, a_r, a_nxt;
  logic [51:0]   x_r, x_nxt;
  logic [26:0]   r_r, r_nxt;
  logic [4:0]    b_r, b_nxt;
  logic [30:0]   s_r, s_nxt;
  logic [33:0]   fac_r, fac_nxt;
  logic [30:0]   p_r, p_nxt;
  logic [2:0]    jc_r, jc_nxt;
  logic [23:0]   q0_r, q0_nxt;
  logic          neg_r, neg_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    oj_r, oj_nxt;
  logic [23:0]   op_r, op_nxt;
  logic          ol_r, ol_nxt;

  logic [23:0]   start_mem [MAX_JOINTS];
  logic [23:0]   final_mem [MAX_JOINTS];

  logic [2:0]    n_eff;
  logic          accept, load_wr;
  logic [AW-1:0] widx, ridx;
  logic [33:0]   mul_a, mul_b;
  logic          mul_go;
  logic [32:0]   trial;
  logic          ge;
  logic [32:0]   rem_step;
  logic [63:0]   quo_step;
  logic          div_last;
  logic [24:0]   dq_in, mag_in, dq_j, mag_j;
  logic [15:0]   v_in, a_in;
  logic [31:0]   elapsed, t1sat;
  logic [26:0]   sq_t;
  logic [27:0]   rr;
  logic [55:0]   rnd;
  logic [26:0]   cmd;
  logic [23:0]   q0_rd_r, qf_rd_r;

  assign n_eff = (cfg_r == 3'd0) ? 3'd1 :
                 (int'(cfg_r) > MAX_JOINTS) ? 3'(MAX_JOINTS) : cfg_r;
  assign in_if.ready = (state_r == S_IDLE);
  assign accept = in_if.valid && in_if.ready;
  assign load_wr = accept && (in_if.op == qjt_pkg::OP_LOAD) && (in_if.joint_index < n_eff);
  assign widx = AW'(in_if.joint_index);
  assign ridx = AW'(jc_nxt);

  assign out_if.valid = ov_r;
  assign out_if.joint_out = oj_r;
  assign out_if.position_command = op_r;
  assign out_if.last_joint = ol_r;

  assign trial = {rem_r[31:0], quo_r[63]};
  assign ge = trial >= {1'b0, dvs_r};
  assign rem_step = ge ? (trial - {1'b0, dvs_r}) : trial;
  assign quo_step = {quo_r[62:0], ge};
  assign div_last = (cnt_r == 7'd1);

  assign dq_in = {in_if.final_position[23], in_if.final_position}
               - {in_if.start_position[23], in_if.start_position};
  assign mag_in = dq_in[24] ? (25'd0 - dq_in) : dq_in;
  assign v_in = (in_if.velocity_limit == 16'd0) ? 16'd1 : in_if.velocity_limit;
  assign a_in = (in_if.accel_limit == 16'd0) ? 16'd1 : in_if.accel_limit;
  assign elapsed = in_if.time_now - tstart_r;
  assign t1sat = (|quo_step[63:32]) ? 32'hFFFF_FFFF : quo_step[31:0];
  assign sq_t = r_r | (27'd1 << b_r);
  assign rr = (prod_r < 68'(x_r)) ? (28'(r_r) + 28'd1) : 28'(r_r);

  assign dq_j = {qf_rd_r[23], qf_rd_r} - {q0_rd_r[23], q0_rd_r};
  assign mag_j = dq_j[24] ? (25'd0 - dq_j) : dq_j;
  assign rnd = prod_r[55:0] + (56'd1 << 29);
  assign cmd = neg_r ? ({{3{q0_r[23]}}, q0_r} - {1'b0, rnd[55:30]})
                     : ({{3{q0_r[23]}}, q0_r} + {1'b0, rnd[55:30]});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    dur_nxt = dur_r;
    tstart_nxt = tstart_r;
    d_nxt = d_r;
    v_nxt = v_r;
    a_nxt = a_r;
    x_nxt = x_r;
    r_nxt = r_r;
    b_nxt = b_r;
    s_nxt = s_r;
    fac_nxt = fac_r;
    p_nxt = p_r;
    jc_nxt = jc_r;
    q0_nxt = q0_r;
    neg_nxt = neg_r;
    ov_nxt = ov_r && !out_if.ready;
    oj_nxt = oj_r;
    op_nxt = op_r;
    ol_nxt = ol_r;
    mul_a = '0;
    mul_b = '0;
    mul_go = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_if.op == qjt_pkg::OP_LOAD) begin
            if (load_wr) begin
              if (in_if.first_of_motion) begin
                dur_nxt = '0;
                tstart_nxt = in_if.time_now;
              end
              d_nxt = mag_in;
              v_nxt = v_in;
              a_nxt = a_in;
              state_nxt = S_LMUL;
            end
          end else if (dur_r == 32'd0 || elapsed >= dur_r) begin
            s_nxt = 31'd1 << 30;
            state_nxt = S_TSQ;
          end else begin
            quo_nxt = {2'b00, elapsed, 30'd0};
            dvs_nxt = dur_r;
            rem_nxt = '0;
            cnt_nxt = 7'd64;
            state_nxt = S_TDIV;
          end
        end
      end
      S_LMUL: begin
        mul_a = 34'(d_r) * 34'd10;
        mul_b = 34'(qjt_pkg::INV_SQRT3_Q32);
        mul_go = 1'b1;
        quo_nxt = 64'(d_r) * 64'd480 + 64'(v_r) - 64'd1;
        dvs_nxt = 32'(v_r);
        rem_nxt = '0;
        cnt_nxt = 7'd64;
        state_nxt = S_LDIV1;
      end
      S_LDIV1: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 7'd1;
        if (div_last) begin
          if (t1sat > dur_r) begin
            dur_nxt = t1sat;
          end
          quo_nxt = prod_r[63:0] + 64'({a_r, 10'd0}) - 64'd1;
          dvs_nxt = 32'({a_r, 10'd0});
          rem_nxt = '0;
          cnt_nxt = 7'd64;
          state_nxt = S_LDIV2;
        end
      end
      S_LDIV2: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 7'd1;
        if (div_last) begin
          x_nxt = quo_step[51:0];
          r_nxt = '0;
          b_nxt = 5'd26;
          state_nxt = S_SQMUL;
        end
      end
      S_SQMUL: begin
        mul_a = 34'(sq_t);
        mul_b = 34'(sq_t);
        mul_go = 1'b1;
        state_nxt = S_SQCMP;
      end
      S_SQCMP: begin
        if (prod_r <= 68'(x_r)) begin
          r_nxt = sq_t;
        end
        if (b_r == 5'd0) begin
          state_nxt = S_SQFIXM;
        end else begin
          b_nxt = b_r - 5'd1;
          state_nxt = S_SQMUL;
        end
      end
      S_SQFIXM: begin
        mul_a = 34'(r_r);
        mul_b = 34'(r_r);
        mul_go = 1'b1;
        state_nxt = S_SQFIXC;
      end
      S_SQFIXC: begin
        if (32'(rr) > dur_r) begin
          dur_nxt = 32'(rr);
        end
        state_nxt = S_IDLE;
      end
      S_TDIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 7'd1;
        if (div_last) begin
          s_nxt = quo_step[30:0];
          state_nxt = S_TSQ;
        end
      end
      S_TSQ: begin
        mul_a = 34'(s_r);
        mul_b = 34'(s_r);
        mul_go = 1'b1;
        state_nxt = S_TCU;
      end
      S_TCU: begin
        mul_a = 34'(prod_r[60:30]);
        mul_b = 34'(s_r);
        mul_go = 1'b1;
        fac_nxt = 34'((36'd10 << 30) + 36'd6 * 36'(prod_r[60:30]) - 36'd15 * 36'(s_r));
        state_nxt = S_TP;
      end
      S_TP: begin
        mul_a = 34'(prod_r[60:30]);
        mul_b = fac_r;
        mul_go = 1'b1;
        state_nxt = S_TPR;
      end
      S_TPR: begin
        p_nxt = prod_r[60:30];
        jc_nxt = '0;
        state_nxt = S_JMUL;
      end
      S_JMUL: begin
        mul_a = 34'(mag_j);
        mul_b = 34'(p_r);
        mul_go = 1'b1;
        q0_nxt = q0_rd_r;
        neg_nxt = dq_j[24];
        state_nxt = S_JOUT;
      end
      S_JOUT: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt = 1'b1;
          oj_nxt = jc_r;
          if ($signed(cmd) > $signed(27'sd8388607)) begin
            op_nxt = 24'h7F_FFFF;
          end else if ($signed(cmd) < -$signed(27'sd8388608)) begin
            op_nxt = 24'h80_0000;
          end else begin
            op_nxt = cmd[23:0];
          end
          ol_nxt = (jc_r == n_eff - 3'd1);
          if (jc_r == n_eff - 3'd1) begin
            state_nxt = S_IDLE;
          end else begin
            jc_nxt = jc_r + 3'd1;
            state_nxt = S_JMUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r <= qjt_pkg::JOINTS_RST;
      dur_r <= '0;
      tstart_r <= '0;
      ov_r <= 1'b0;
      cnt_r <= '0;
      jc_r <= '0;
      b_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      dur_r <= dur_nxt;
      tstart_r <= tstart_nxt;
      ov_r <= ov_nxt;
      cnt_r <= cnt_nxt;
      jc_r <= jc_nxt;
      b_r <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    d_r <= d_nxt;
    v_r <= v_nxt;
    a_r <= a_nxt;
    x_r <= x_nxt;
    r_r <= r_nxt;
    s_r <= s_nxt;
    fac_r <= fac_nxt;
    p_r <= p_nxt;
    q0_r <= q0_nxt;
    neg_r <= neg_nxt;
    oj_r <= oj_nxt;
    op_r <= op_nxt;
    ol_r <= ol_nxt;
    if (mul_go) begin
      prod_r <= 68'(mul_a) * 68'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      start_mem[widx] <= in_if.start_position;
      final_mem[widx] <= in_if.final_position;
    end
    q0_rd_r <= start_mem[ridx];
    qf_rd_r <= final_mem[ridx];
  end

`include "assert_macros.svh"

  `QJT_ASSERT(a_last_matches_count, out_if.valid && out_if.last_joint |-> (out_if.joint_out + 3'd1 == n_eff))
  `QJT_ASSERT_NEXT(a_busy_after_tick, accept && (in_if.op == qjt_pkg::OP_TICK), !in_if.ready)
  `QJT_ASSERT(a_run_continues, out_if.valid && out_if.ready && !out_if.last_joint |-> state_r != S_IDLE)

endmodule
